FILE: sv/poa_pkg.sv
// Shared constants, codes and the token type for the page owner allocator.
package poa_pkg;

    localparam int FRAMES     = 16;
    localparam int OWNER_BITS = 8;
    localparam int MAX_BYTES  = 2 * FRAMES;
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int OUT_CNT_W  = 5;
    localparam int PORT_OWN_W = 8;

    typedef logic [OWNER_BITS-1:0] owner_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_BAD_OWNER = 2'd3
    } status_t;

    // The token that walks down the row of frame cells, one cell per cycle.
    typedef struct packed {
        logic   valid;
        op_t    op;
        owner_t owner;
        cnt_t   remain;
        cnt_t   count;
    } tok_t;

endpackage

FILE: sv/poa_cell.sv
// One page frame: holds the owner of the frame and updates the passing token.
module poa_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  poa_pkg::tok_t tok_in,
    output poa_pkg::tok_t tok_out
);

    poa_pkg::owner_t entry_reg;
    poa_pkg::owner_t entry_next;
    poa_pkg::tok_t   tok_reg;
    poa_pkg::tok_t   tok_next;

    always_comb
    begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                poa_pkg::OP_RESERVE:
                begin
                    if (entry_reg == '0 && tok_in.remain != '0)
                    begin
                        entry_next      = tok_in.owner;
                        tok_next.remain = tok_in.remain - poa_pkg::CNT_W'(1);
                        tok_next.count  = tok_in.count + poa_pkg::CNT_W'(1);
                    end
                end
                poa_pkg::OP_RELEASE:
                begin
                    if (entry_reg == tok_in.owner)
                    begin
                        entry_next     = '0;
                        tok_next.count = tok_in.count + poa_pkg::CNT_W'(1);
                    end
                end
                poa_pkg::OP_QUERY:
                begin
                    if (entry_reg == tok_in.owner)
                    begin
                        tok_next.count = tok_in.count + poa_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: sv/page_owner_allocator_unit.sv
// Top level of the page owner allocator: command decode, checks and the row of frame cells.
//
// A command is taken when start is high and busy is low. A reserve, release or query that
// passes its checks sends a token through the row of FRAMES frame cells, one cell per cycle;
// its result appears when the token leaves the last cell, and busy stays high meanwhile. A
// rejected command or an unused op changes no state and gives its result in the cycle right
// after the transfer, with busy staying low. Each result is shown for exactly one cycle with
// done high; the receiver cannot stall it, and the next command may be taken in that same cycle.
module page_owner_allocator_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [7:0] byte_count,
    input  logic [7:0] owner,
    input  logic       fresh_owner,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] owner_used,
    output logic [4:0] page_count,
    output logic [4:0] free_pages
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    poa_pkg::cnt_t      free_cnt_reg, free_cnt_next;
    poa_pkg::owner_t    last_id_reg, last_id_next;
    poa_pkg::op_t       cur_op_reg, cur_op_next;
    poa_pkg::owner_t    cur_owner_reg, cur_owner_next;
    logic               done_reg, done_next;
    poa_pkg::status_t   status_reg, status_next;
    poa_pkg::owner_t    used_reg, used_next;
    poa_pkg::cnt_t      pages_reg, pages_next;

    poa_pkg::tok_t      chain [0:poa_pkg::FRAMES];

    logic               accept;
    poa_pkg::op_t       op_in;
    poa_pkg::owner_t    owner_in;
    poa_pkg::owner_t    fresh_id;
    poa_pkg::owner_t    res_owner;
    logic [7:0]         need;
    logic               too_large;
    logic               no_space;
    poa_pkg::tok_t      tail;

    assign accept   = start && (state_reg == S_IDLE);
    assign op_in    = poa_pkg::op_t'(op);
    assign owner_in = poa_pkg::owner_t'(owner);
    assign need     = {1'b0, byte_count[7:1]} + {7'd0, byte_count[0]};
    assign too_large = 32'(byte_count) > 32'(poa_pkg::MAX_BYTES);
    assign no_space  = 32'(need) > 32'(free_cnt_reg);

    always_comb
    begin
        fresh_id = last_id_reg + poa_pkg::OWNER_BITS'(1);
        if (fresh_id == '0)
        begin
            fresh_id = poa_pkg::OWNER_BITS'(1);
        end
    end

    assign res_owner = fresh_owner ? fresh_id : owner_in;
    assign tail      = chain[poa_pkg::FRAMES];

    always_comb
    begin
        state_next     = state_reg;
        free_cnt_next  = free_cnt_reg;
        last_id_next   = last_id_reg;
        cur_op_next    = cur_op_reg;
        cur_owner_next = cur_owner_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        used_next      = used_reg;
        pages_next     = pages_reg;
        chain[0]       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    used_next      = owner_in;
                    pages_next     = '0;
                    status_next    = poa_pkg::ST_OK;
                    cur_op_next    = op_in;
                    cur_owner_next = owner_in;
                    done_next      = 1'b1;
                    unique case (op_in)
                        poa_pkg::OP_RESERVE:
                        begin
                            if (!fresh_owner && owner_in == '0)
                                status_next = poa_pkg::ST_BAD_OWNER;
                            else if (too_large)
                                status_next = poa_pkg::ST_TOO_LARGE;
                            else if (no_space)
                                status_next = poa_pkg::ST_NO_SPACE;
                            else
                            begin
                                if (fresh_owner)
                                    last_id_next = fresh_id;
                                cur_owner_next  = res_owner;
                                chain[0].valid  = 1'b1;
                                chain[0].op     = op_in;
                                chain[0].owner  = res_owner;
                                chain[0].remain = poa_pkg::CNT_W'(need);
                                chain[0].count  = '0;
                                done_next       = 1'b0;
                                state_next      = S_RUN;
                            end
                        end
                        poa_pkg::OP_RELEASE, poa_pkg::OP_QUERY:
                        begin
                            if (owner_in == '0)
                                status_next = poa_pkg::ST_BAD_OWNER;
                            else
                            begin
                                chain[0].valid  = 1'b1;
                                chain[0].op     = op_in;
                                chain[0].owner  = owner_in;
                                chain[0].remain = '0;
                                chain[0].count  = '0;
                                done_next       = 1'b0;
                                state_next      = S_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (tail.valid)
                begin
                    done_next   = 1'b1;
                    status_next = poa_pkg::ST_OK;
                    used_next   = cur_owner_reg;
                    pages_next  = tail.count;
                    state_next  = S_IDLE;
                    // Fold the frames claimed or freed into the free count.
                    priority if (cur_op_reg == poa_pkg::OP_RESERVE)
                        free_cnt_next = free_cnt_reg - tail.count;
                    else if (cur_op_reg == poa_pkg::OP_RELEASE)
                        free_cnt_next = free_cnt_reg + tail.count;
                    else
                        free_cnt_next = free_cnt_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < poa_pkg::FRAMES; g++)
    begin : g_cell
        poa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            free_cnt_reg <= poa_pkg::CNT_W'(poa_pkg::FRAMES);
            last_id_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            last_id_reg  <= last_id_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg    <= cur_op_next;
        cur_owner_reg <= cur_owner_next;
        status_reg    <= status_next;
        used_reg      <= used_next;
        pages_reg     <= pages_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign owner_used = poa_pkg::PORT_OWN_W'(used_reg);
    assign page_count = poa_pkg::OUT_CNT_W'(pages_reg);
    assign free_pages = poa_pkg::OUT_CNT_W'(free_cnt_reg);

endmodule
